// ----- hw/rtl/encoder_frame_crc_speed_macros.svh -----
// Assertion macros for the encoder frame CRC and speed block.
// Used by the port checker; the enclosing scope must provide clk and rst_n.
`ifndef ENCODER_FRAME_CRC_SPEED_MACROS_SVH
`define ENCODER_FRAME_CRC_SPEED_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define EFCS_ASSERT_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define EFCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/efcs_pkg.sv -----
// Shared constants and the CRC-6 function for the encoder frame CRC and speed block.
// No dependencies; imported by the interfaces and every module.
`default_nettype none

package efcs_pkg;

    localparam int STATUS_W      = 4;
    localparam int CRC_W         = 6;
    localparam int SPEED_W       = 22;
    localparam int PAYLOAD_MAX_W = 22;

    localparam logic [CRC_W:0] CRC_POLY = 7'h43;

    // Filter numerator bounds that still map onto the saturated speed range
    localparam int NUM_HI  = 20971519;
    localparam int NUM_LO  = -20971529;
    localparam int MAG_W   = 25;

    // Divide by ten: multiply by ceil(2^35 / 10) and keep bits 35 and up
    localparam int          RECIP_W     = 32;
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    // MSB first, initial value zero; leading zero bits leave the CRC at zero
    function automatic logic [CRC_W-1:0] crc6_calc(input logic [PAYLOAD_MAX_W-1:0] bits);
        logic [CRC_W-1:0] crc;
        logic             fb;
        crc = '0;
        for (int i = PAYLOAD_MAX_W - 1; i >= 0; i--)
        begin
            fb  = crc[CRC_W-1] ^ bits[i];
            crc = {crc[CRC_W-2:0], 1'b0};
            if (fb)
            begin
                crc = crc ^ CRC_POLY[CRC_W-1:0];
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/efcs_ifs.sv -----
// Valid/ready channel interfaces: raw frames in, checked items between stages,
// decoded results out. Depends on efcs_pkg.
`default_nettype none

interface efcs_frame_if #(parameter int ANGLE_BITS = 14);
    import efcs_pkg::*;
    logic                                  valid;
    logic                                  ready;
    logic [ANGLE_BITS+STATUS_W+CRC_W-1:0]  frame;
    modport source (output valid, output frame, input ready);
    modport sink   (input valid, input frame, output ready);
endinterface

interface efcs_item_if #(parameter int ANGLE_BITS = 14);
    import efcs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [ANGLE_BITS-1:0] angle;
    logic [STATUS_W-1:0]   status;
    logic                  crc_ok;
    modport source (output valid, output angle, output status, output crc_ok, input ready);
    modport sink   (input valid, input angle, input status, input crc_ok, output ready);
endinterface

interface efcs_result_if #(parameter int ANGLE_BITS = 14);
    import efcs_pkg::*;
    logic                         valid;
    logic                         ready;
    logic [ANGLE_BITS-1:0]        angle_counts;
    logic [STATUS_W-1:0]          magnet_status;
    logic                         crc_ok;
    logic signed [ANGLE_BITS-1:0] angle_step;
    logic signed [SPEED_W-1:0]    speed_estimate;
    modport source (output valid, output angle_counts, output magnet_status, output crc_ok,
                    output angle_step, output speed_estimate, input ready);
    modport sink   (input valid, input angle_counts, input magnet_status, input crc_ok,
                    input angle_step, input speed_estimate, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/efcs_front.sv -----
// Front stage: accepts a raw frame, checks its CRC-6 and registers the split item.
// Depends on efcs_pkg and the channel interfaces.
`default_nettype none

module efcs_front #(
    parameter int ANGLE_BITS = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    efcs_frame_if.sink  frames,
    efcs_item_if.source item
);
    import efcs_pkg::*;

    localparam int PAYLOAD_W = ANGLE_BITS + STATUS_W;

    logic [PAYLOAD_W-1:0]  payload;
    logic [CRC_W-1:0]      crc_rx;
    logic                  accept;
    logic                  vld_reg;
    logic                  vld_next;
    logic [ANGLE_BITS-1:0] angle_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic                  ok_reg;

    assign payload = frames.frame[CRC_W +: PAYLOAD_W];
    assign crc_rx  = frames.frame[CRC_W-1:0];

    assign frames.ready = !vld_reg || item.ready;
    assign accept       = frames.valid && frames.ready;
    assign vld_next     = accept || (vld_reg && !item.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            angle_reg  <= payload[STATUS_W +: ANGLE_BITS];
            status_reg <= payload[STATUS_W-1:0];
            ok_reg     <= (crc6_calc(PAYLOAD_MAX_W'(payload)) == crc_rx);
        end
    end

    assign item.valid  = vld_reg;
    assign item.angle  = angle_reg;
    assign item.status = status_reg;
    assign item.crc_ok = ok_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/efcs_queue.sv -----
// Two-entry queue of checked items between the front and back stages.
// Depends on efcs_pkg and the channel interfaces.
`default_nettype none

module efcs_queue #(
    parameter int ANGLE_BITS = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    efcs_item_if.sink   wr,
    efcs_item_if.source rd
);
    import efcs_pkg::*;

    localparam int DEPTH   = 2;
    localparam int ENTRY_W = ANGLE_BITS + STATUS_W + 1;

    logic [ENTRY_W-1:0] mem_reg [DEPTH];
    logic [ENTRY_W-1:0] rd_entry;
    logic [1:0]         count_reg;
    logic [1:0]         count_next;
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic               push;
    logic               pop;

    assign wr.ready = (count_reg != 2'(DEPTH));
    assign rd.valid = (count_reg != 2'd0);
    assign push     = wr.valid && wr.ready;
    assign pop      = rd.valid && rd.ready;

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= {wr.angle, wr.status, wr.crc_ok};
        end
    end

    assign rd_entry  = mem_reg[rd_ptr_reg];
    assign rd.angle  = rd_entry[ENTRY_W-1 -: ANGLE_BITS];
    assign rd.status = rd_entry[1 +: STATUS_W];
    assign rd.crc_ok = rd_entry[0];

endmodule

`default_nettype wire

// ----- hw/rtl/efcs_back.sv -----
// Back stage: wraps the angle step, runs the speed low-pass filter and holds
// the result register. Depends on efcs_pkg and the channel interfaces.
`default_nettype none

module efcs_back #(
    parameter int ANGLE_BITS      = 14,
    parameter int SPEED_FRAC_BITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    efcs_item_if.sink     item,
    efcs_result_if.source results
);
    import efcs_pkg::*;

    localparam int SCALED_W = ANGLE_BITS + SPEED_FRAC_BITS;
    localparam int NUM_W    = ((SCALED_W > SPEED_W + 4) ? SCALED_W : SPEED_W + 4) + 1;
    localparam int PROD_W   = MAG_W + RECIP_W;

    localparam logic signed [NUM_W-1:0] NUM_HI_N = NUM_W'(NUM_HI);
    localparam logic signed [NUM_W-1:0] NUM_LO_N = NUM_W'(NUM_LO);

    logic                         pop;
    logic [ANGLE_BITS-1:0]        prev_angle_reg;
    logic signed [SPEED_W-1:0]    speed_reg;
    logic [ANGLE_BITS-1:0]        diff;
    logic signed [ANGLE_BITS-1:0] step;
    logic signed [NUM_W-1:0]      step_scaled;
    logic signed [NUM_W-1:0]      speed_ext;
    logic signed [NUM_W-1:0]      num;
    logic signed [NUM_W-1:0]      num_sat;
    logic signed [NUM_W-1:0]      num_mag;
    logic                         num_neg;
    logic [PROD_W-1:0]            prod;
    logic [SPEED_W-1:0]           quot;
    logic signed [SPEED_W-1:0]    speed_new;

    logic                         out_vld_reg;
    logic                         out_vld_next;
    logic [ANGLE_BITS-1:0]        out_angle_reg;
    logic [STATUS_W-1:0]          out_status_reg;
    logic                         out_ok_reg;
    logic signed [ANGLE_BITS-1:0] out_step_reg;
    logic signed [SPEED_W-1:0]    out_speed_reg;

    assign item.ready   = !out_vld_reg || results.ready;
    assign pop          = item.valid && item.ready;
    assign out_vld_next = pop || (out_vld_reg && !results.ready);

    // Modular difference read as signed gives the half-turn wrap directly
    assign diff = item.angle - prev_angle_reg;
    assign step = $signed(diff);

    assign step_scaled = NUM_W'(step) <<< SPEED_FRAC_BITS;
    assign speed_ext   = NUM_W'(speed_reg);
    assign num         = step_scaled + (speed_ext <<< 3) + speed_ext;

    // Clamp first so the quotient saturates and the divide stays narrow
    always_comb
    begin
        priority if (num > NUM_HI_N)
        begin
            num_sat = NUM_HI_N;
        end
        else if (num < NUM_LO_N)
        begin
            num_sat = NUM_LO_N;
        end
        else
        begin
            num_sat = num;
        end
    end

    assign num_neg   = num_sat[NUM_W-1];
    assign num_mag   = num_neg ? -num_sat : num_sat;
    assign prod      = num_mag[MAG_W-1:0] * RECIP_TEN;
    assign quot      = prod[RECIP_SHIFT +: SPEED_W];
    assign speed_new = num_neg ? -$signed(quot) : $signed(quot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg    <= 1'b0;
            prev_angle_reg <= '0;
            speed_reg      <= '0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
            if (pop && item.crc_ok)
            begin
                prev_angle_reg <= item.angle;
                speed_reg      <= speed_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_status_reg <= item.status;
            out_ok_reg     <= item.crc_ok;
            if (item.crc_ok)
            begin
                out_angle_reg <= item.angle;
                out_step_reg  <= step;
                out_speed_reg <= speed_new;
            end
            else
            begin
                // hold state, report no movement
                out_angle_reg <= prev_angle_reg;
                out_step_reg  <= '0;
                out_speed_reg <= speed_reg;
            end
        end
    end

    assign results.valid          = out_vld_reg;
    assign results.angle_counts   = out_angle_reg;
    assign results.magnet_status  = out_status_reg;
    assign results.crc_ok         = out_ok_reg;
    assign results.angle_step     = out_step_reg;
    assign results.speed_estimate = out_speed_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/encoder_frame_crc_speed.sv -----
// Encoder frame decoder with CRC-6 check and low-pass speed estimate (top level).
// Depends on efcs_pkg, the channel interfaces, efcs_front, efcs_queue, efcs_back.
//
// Usage:
//   frames  - valid/ready sink of raw frames: angle, four status bits, CRC-6.
//   results - valid/ready source, one item per frame: angle, status, CRC flag,
//             wrapped angle step and filtered speed (Q SPEED_FRAC_BITS).
//   A frame with a bad CRC leaves angle and speed untouched and reports a
//   zero step; status bits are always taken from the frame.
//   Each frame passes the front register, the queue and the result register in turn.
//   Throughput: one frame per cycle while results is not stalled; the speed
//   register feeds back through a single multiply-by-reciprocal divide by
//   ten in the back stage, which closes the filter loop through that register.
//   A two-item queue sits between front and back, and the result register
//   frees as it is taken, so frames keep being accepted while a result waits.
//   When results stalls, up to four frames are held (front register, queue,
//   result register); frames.ready drops only while front and queue are full.
//   Reset clears the stored angle and speed to zero and empties the pipeline;
//   the first good frame measures its step from angle zero.
`default_nettype none

module encoder_frame_crc_speed #(
    parameter int ANGLE_BITS      = 14,
    parameter int SPEED_FRAC_BITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    efcs_frame_if.sink    frames,
    efcs_result_if.source results
);
    import efcs_pkg::*;

    efcs_item_if #(.ANGLE_BITS(ANGLE_BITS)) front_to_queue ();
    efcs_item_if #(.ANGLE_BITS(ANGLE_BITS)) queue_to_back ();

    efcs_front #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .frames (frames),
        .item   (front_to_queue)
    );

    efcs_queue #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (front_to_queue),
        .rd    (queue_to_back)
    );

    efcs_back #(
        .ANGLE_BITS      (ANGLE_BITS),
        .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (queue_to_back),
        .results (results)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/efcs_checker.sv -----
// Port-level checker for encoder_frame_crc_speed, attached by bind below.
// Depends on efcs_pkg and encoder_frame_crc_speed_macros.svh.
`default_nettype none
`include "encoder_frame_crc_speed_macros.svh"

module efcs_checker #(
    parameter int ANGLE_BITS = 14
) (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  frame_valid,
    input logic                                  frame_ready,
    input logic                                  res_valid,
    input logic                                  res_ready,
    input logic [ANGLE_BITS-1:0]                 angle_counts,
    input logic [efcs_pkg::STATUS_W-1:0]         magnet_status,
    input logic                                  crc_ok,
    input logic signed [ANGLE_BITS-1:0]          angle_step,
    input logic signed [efcs_pkg::SPEED_W-1:0]   speed_estimate
);
    import efcs_pkg::*;

    // A stalled result holds still
    `EFCS_ASSERT_NEXT(a_stall_hold, res_valid && !res_ready, res_valid && $stable(angle_counts) && $stable(magnet_status) && $stable(crc_ok) && $stable(angle_step) && $stable(speed_estimate), "result changed while stalled")

    // Every accepted frame is followed by some result on the port
    `EFCS_ASSERT_NEXT(a_result_fill, frame_valid && frame_ready, 1'b1 ##2 res_valid, "no result three cycles after frame")

    // Back-pressure only ever comes from a waiting result
    `EFCS_ASSERT_HOLDS(a_ready_cause, !frame_ready, res_valid, "frames stalled with no result pending")

    // A bad frame reports no movement
    `EFCS_ASSERT_HOLDS(a_bad_crc_step, res_valid && !crc_ok, angle_step == '0, "nonzero step on CRC failure")

endmodule

bind encoder_frame_crc_speed efcs_checker #(
    .ANGLE_BITS(ANGLE_BITS)
) u_efcs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .frame_valid    (frames.valid),
    .frame_ready    (frames.ready),
    .res_valid      (results.valid),
    .res_ready      (results.ready),
    .angle_counts   (results.angle_counts),
    .magnet_status  (results.magnet_status),
    .crc_ok         (results.crc_ok),
    .angle_step     (results.angle_step),
    .speed_estimate (results.speed_estimate)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench for encoder_frame_crc_speed: drives encoder frames, predicts angle,
// step and filtered speed per frame, and checks each result item in order.
// Depends on efcs_pkg, the channel interfaces and the encoder_frame_crc_speed RTL.
`default_nettype none

module tb_top;
    import efcs_pkg::STATUS_W;
    import efcs_pkg::CRC_W;
    import efcs_pkg::SPEED_W;

    localparam int ANGLE_W     = 14;
    localparam int FRAC_W      = 8;
    localparam int PAYLOAD_W   = ANGLE_W + STATUS_W;
    localparam int FRAME_W     = PAYLOAD_W + CRC_W;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 6;
    localparam int IDLE_PCT    = 8;

    // Low taps of x^6+x+1; the x^6 term falls off the top of the register
    localparam logic [CRC_W-1:0] CRC6_TAPS = 6'h03;
    localparam longint SPEED_TOP = 64'sd2097151;
    localparam longint SPEED_BOT = -64'sd2097152;

    typedef struct {
        logic [ANGLE_W-1:0]        angle;
        logic [STATUS_W-1:0]       status;
        logic                      ok;
        logic signed [ANGLE_W-1:0] step;
        logic signed [SPEED_W-1:0] speed;
    } decode_t;

    logic clk = 1'b0;
    logic rst_n;
    logic full_rate;
    int   cycle_count = 0;
    int   error_count = 0;

    // Decoder state as the block should hold it
    logic [ANGLE_W-1:0]        held_angle;
    logic signed [SPEED_W-1:0] held_speed;
    decode_t                   pending_decodes[$];

    efcs_frame_if  #(.ANGLE_BITS(ANGLE_W)) frames_if ();
    efcs_result_if #(.ANGLE_BITS(ANGLE_W)) results_if ();

    encoder_frame_crc_speed #(
        .ANGLE_BITS      (ANGLE_W),
        .SPEED_FRAC_BITS (FRAC_W)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .frames  (frames_if),
        .results (results_if)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        results_if.ready <= full_rate || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic logic [CRC_W-1:0] crc6_of(input logic [PAYLOAD_W-1:0] payload);
        logic [CRC_W-1:0] reg6;
        logic             fb;
        int               i;
        reg6 = '0;
        for (i = PAYLOAD_W - 1; i >= 0; i--)
        begin
            fb   = reg6[CRC_W-1] ^ payload[i];
            reg6 = reg6 << 1;
            if (fb)
            begin
                reg6 = reg6 ^ CRC6_TAPS;
            end
        end
        return reg6;
    endfunction

    function automatic logic [FRAME_W-1:0] good_frame(input logic [ANGLE_W-1:0] angle,
                                                      input logic [STATUS_W-1:0] status);
        return {angle, status, crc6_of({angle, status})};
    endfunction

    // Decode one accepted frame and advance the held angle and speed
    function automatic decode_t advance_decoder(input logic [FRAME_W-1:0] f);
        decode_t            r;
        logic [ANGLE_W-1:0] diff;
        longint             acc;
        r.status = f[CRC_W +: STATUS_W];
        r.ok     = (crc6_of(f[FRAME_W-1:CRC_W]) == f[CRC_W-1:0]);
        r.step   = '0;
        if (r.ok)
        begin
            // Modular difference read as two's complement gives the half-turn wrap
            diff   = f[FRAME_W-1 -: ANGLE_W] - held_angle;
            r.step = diff;
            acc    = longint'(r.step) * (longint'(1) << FRAC_W) + 9 * longint'(held_speed);
            acc    = acc / 10;
            if (acc > SPEED_TOP)
            begin
                acc = SPEED_TOP;
            end
            if (acc < SPEED_BOT)
            begin
                acc = SPEED_BOT;
            end
            held_speed = acc[SPEED_W-1:0];
            held_angle = f[FRAME_W-1 -: ANGLE_W];
        end
        r.angle = held_angle;
        r.speed = held_speed;
        return r;
    endfunction

    task automatic send_frame(input logic [FRAME_W-1:0] f);
        while (!full_rate && ($urandom_range(99) < IDLE_PCT))
        begin
            frames_if.valid <= 1'b0;
            @(posedge clk);
        end
        frames_if.valid <= 1'b1;
        frames_if.frame <= f;
        @(posedge clk);
        while (!frames_if.ready)
        begin
            @(posedge clk);
        end
        pending_decodes.push_back(advance_decoder(f));
    endtask

    // Corrupt one random bit; a single-bit error always breaks CRC-6
    function automatic logic [FRAME_W-1:0] flip_one(input logic [FRAME_W-1:0] f);
        return f ^ (24'h1 << $urandom_range(FRAME_W - 1));
    endfunction

    always @(posedge clk)
    begin : check_results
        decode_t want;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (pending_decodes.size() == 0)
            begin
                $error("result item with nothing expected");
                error_count++;
            end
            else
            begin
                want = pending_decodes.pop_front();
                if (results_if.angle_counts !== want.angle)
                begin
                    $error("angle_counts: expected %0d, got %0d", want.angle,
                           results_if.angle_counts);
                    error_count++;
                end
                if (results_if.magnet_status !== want.status)
                begin
                    $error("magnet_status: expected %0h, got %0h", want.status,
                           results_if.magnet_status);
                    error_count++;
                end
                if (results_if.crc_ok !== want.ok)
                begin
                    $error("crc_ok: expected %0b, got %0b", want.ok, results_if.crc_ok);
                    error_count++;
                end
                if (results_if.angle_step !== want.step)
                begin
                    $error("angle_step: expected %0d, got %0d", want.step,
                           results_if.angle_step);
                    error_count++;
                end
                if (results_if.speed_estimate !== want.speed)
                begin
                    $error("speed_estimate: expected %0d, got %0d", want.speed,
                           results_if.speed_estimate);
                    error_count++;
                end
            end
        end
    end

    // Bad CRC at reset, first good frame from zero, wraps, each CRC bit broken
    task automatic test_first_frames();
        int k;
        send_frame(good_frame(14'd0, 4'h0) ^ 24'h1);
        send_frame(24'hFFFFFF);
        send_frame(good_frame(14'd5000, 4'h5));
        send_frame(good_frame(14'd0, 4'h0));
        send_frame(good_frame(14'd16383, 4'hF));
        send_frame(good_frame(14'd8191, 4'hA));
        send_frame(good_frame(14'd0, 4'h0));
        send_frame(good_frame(14'd8191, 4'h3));
        send_frame(good_frame(14'd8191, 4'hC));
        for (k = 0; k < CRC_W; k++)
        begin
            send_frame(good_frame(14'd1234, k[STATUS_W-1:0]) ^ (24'h1 << k));
        end
        send_frame(good_frame(14'd0, 4'h0) ^ (24'h1 << (FRAME_W - 1)));
        send_frame(good_frame(14'd1, 4'h6));
        send_frame(good_frame(14'd8193, 4'h9));
        send_frame(24'h000000);
        send_frame(good_frame(14'd16383, 4'hF) ^ (24'h1 << CRC_W));
    endtask

    function automatic logic [ANGLE_W-1:0] pick_step();
        logic [ANGLE_W-1:0] edge_steps[4];
        edge_steps = '{14'h1FFF, 14'h2000, 14'h2001, 14'h3FFF};
        case ($urandom_range(5))
            0: return edge_steps[$urandom_range(3)];
            1: return ANGLE_W'($urandom_range(64)) - 14'd32;
            default: return ANGLE_W'($urandom_range(16383));
        endcase
    endfunction

    // Runs of constant speed drive the filter to its limits; a few frames get corrupted
    task automatic test_rotation_runs(input int count, input int corrupt_pct);
        logic [ANGLE_W-1:0]  angle;
        logic [ANGLE_W-1:0]  step;
        logic [FRAME_W-1:0]  f;
        int                  sent;
        int                  run_len;
        int                  i;
        angle = ANGLE_W'($urandom_range(16383));
        sent  = 0;
        while (sent < count)
        begin
            step    = pick_step();
            run_len = $urandom_range(60, 1);
            for (i = 0; i < run_len; i++)
            begin
                angle = angle + step;
                f     = good_frame(angle, STATUS_W'($urandom_range(15)));
                if ($urandom_range(99) < corrupt_pct)
                begin
                    f = flip_one(f);
                end
                send_frame(f);
                sent++;
            end
        end
    endtask

    task automatic test_full_rate();
        full_rate = 1'b1;
        test_rotation_runs(150, 5);
        full_rate = 1'b0;
    endtask

    task automatic test_noisy_frames(input int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 60)
            begin
                send_frame(good_frame(ANGLE_W'($urandom_range(16383)),
                                      STATUS_W'($urandom_range(15))));
            end
            else
            begin
                send_frame(FRAME_W'($urandom()));
            end
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        full_rate        = 1'b0;
        held_angle       = '0;
        held_speed       = '0;
        frames_if.valid  = 1'b0;
        frames_if.frame  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_frames();
        test_rotation_runs(500, 10);
        test_full_rate();
        test_noisy_frames(480);

        frames_if.valid <= 1'b0;
        while (pending_decodes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
